// ===== rtl/srf_pkg.sv =====
`timescale 1ns / 1ps

package srf_pkg;

  localparam int unsigned RULE_SLOTS_DEF = 512;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] KIND_BLOCK = 8'h01;
  localparam logic [7:0] KIND_LOG = 8'h03;

  typedef enum logic {
    OP_CHECK = 1'b0,
    OP_LOAD  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } back_state_e;

  typedef struct packed {
    logic [6:0]  pad;
    logic [63:0] new_name_high;
    logic [63:0] new_name_low;
    logic        new_enabled;
    logic [7:0]  new_kind;
    logic [63:0] proc_name_high;
    logic [63:0] proc_name_low;
    logic [63:0] time_ns;
    logic [31:0] process_id;
    logic [31:0] call_number;
  } in_data_t;

  localparam int unsigned IN_DATA_W = $bits(in_data_t);

  typedef struct packed {
    logic [63:0] exported_total;
    logic [63:0] logged_total;
    logic [63:0] blocked_total;
    logic [63:0] checked_total;
    logic [63:0] slot_fires;
    logic [31:0] hit_name_high;
    logic [63:0] hit_name_low;
    logic [63:0] hit_time;
    logic [31:0] hit_pid;
    logic [31:0] hit_number;
    logic [7:0]  hit_kind;
  } out_data_t;

  localparam int unsigned OUT_DATA_W = $bits(out_data_t);

  typedef struct packed {
    op_e         op;
    logic        in_range;
    logic [31:0] number;
    logic [31:0] pid;
    logic [63:0] time_ns;
    logic [63:0] proc_low;
    logic [63:0] proc_high;
    logic [7:0]  kind;
    logic        enabled;
    logic [63:0] name_low;
    logic [63:0] name_high;
  } job_t;

  typedef struct packed {
    logic        valid;
    logic        enabled;
    logic [7:0]  kind;
    logic [63:0] name_low;
    logic [63:0] name_high;
    logic [63:0] fires;
  } rule_t;

endpackage

// ===== rtl/srf_ram.sv =====
`timescale 1ns / 1ps

module srf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/srf_front.sv =====
`timescale 1ns / 1ps

module srf_front import srf_pkg::*; #(
  parameter int unsigned RULE_SLOTS = RULE_SLOTS_DEF
) (
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [IN_DATA_W-1:0] s_tdata_i,
  input  logic [0:0]           s_tuser_i,
  input  logic                 clear_busy_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output job_t                 job_o
);

  in_data_t din;

  assign din = in_data_t'(s_tdata_i);
  assign s_tready_o = !clear_busy_i && !q_full_i;
  assign push_o = s_tvalid_i && s_tready_o;

  always_comb begin
    job_o.op        = op_e'(s_tuser_i[0]);
    job_o.in_range  = din.call_number < 32'(RULE_SLOTS);
    job_o.number    = din.call_number;
    job_o.pid       = din.process_id;
    job_o.time_ns   = din.time_ns;
    job_o.proc_low  = din.proc_name_low;
    job_o.proc_high = din.proc_name_high;
    job_o.kind      = din.new_kind;
    job_o.enabled   = din.new_enabled;
    job_o.name_low  = din.new_name_low;
    job_o.name_high = din.new_name_high;
  end

endmodule

// ===== rtl/srf_queue.sv =====
`timescale 1ns / 1ps

module srf_queue import srf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t                slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;

  assign full_o  = count_q == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign job_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (QUEUE_AW+1)'(push_i) - (QUEUE_AW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("queue popped while empty");
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue pushed while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   count_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/srf_back.sv =====
`timescale 1ns / 1ps

module srf_back import srf_pkg::*; #(
  parameter int unsigned RULE_SLOTS = RULE_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  job_t                  job_i,
  output logic                  pop_o,
  output logic                  clear_busy_o,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  output logic [0:0]            m_tuser_o
);

  localparam int unsigned AW = $clog2(RULE_SLOTS);
  localparam int unsigned RW = $bits(rule_t);

  back_state_e state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  rule_t         ram_wdata;
  logic [RW-1:0] ram_rdata;
  rule_t         rd;
  logic [AW-1:0] idx;

  logic [63:0] check_q, check_d;
  logic [63:0] block_q, block_d;
  logic [63:0] log_q, log_d;
  logic [63:0] export_q, export_d;

  logic      out_valid_q, out_valid_d;
  out_data_t out_data_q;
  logic      out_blocked_q;
  logic      out_load;
  logic      out_free;
  logic      hit;
  logic      is_block;
  logic      is_log;
  logic      inc_check;
  logic      inc_hit;
  logic [63:0] fires_next;

  function automatic logic name_match(logic [63:0] rlo, logic [63:0] rhi,
                                      logic [63:0] plo, logic [63:0] phi);
    logic [127:0] r;
    logic [127:0] p;
    logic         seen_zero;
    logic         ok;
    r = {rhi, rlo};
    p = {phi, plo};
    seen_zero = 1'b0;
    ok = 1'b1;
    for (int i = 0; i < 16; i++) begin
      seen_zero = seen_zero | (r[8*i +: 8] == 8'h00);
      ok = ok & (seen_zero | (r[8*i +: 8] == p[8*i +: 8]));
    end
    return ok;
  endfunction

  srf_ram #(
    .WIDTH (RW),
    .DEPTH (RULE_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx),
    .rdata_o (ram_rdata)
  );

  assign rd         = rule_t'(ram_rdata);
  assign idx        = job_i.number[AW-1:0];
  assign out_free   = !out_valid_q || m_tready_i;
  assign hit        = rd.valid && rd.enabled &&
                      name_match(rd.name_low, rd.name_high, job_i.proc_low, job_i.proc_high);
  assign is_block   = rd.kind == KIND_BLOCK;
  assign is_log     = rd.kind == KIND_LOG;
  assign fires_next = rd.fires + 64'(is_block);

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(RULE_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (job_valid_i && job_i.op == OP_CHECK && job_i.in_range) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!hit || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    pop_o     = 1'b0;
    inc_check = 1'b0;
    inc_hit   = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
      end
      ST_IDLE: begin
        if (job_valid_i) begin
          if (job_i.op == OP_LOAD) begin
            pop_o             = 1'b1;
            ram_we            = job_i.in_range;
            ram_wdata.valid     = 1'b1;
            ram_wdata.enabled   = job_i.enabled;
            ram_wdata.kind      = job_i.kind;
            ram_wdata.name_low  = job_i.name_low;
            ram_wdata.name_high = job_i.name_high;
          end else if (!job_i.in_range) begin
            pop_o     = 1'b1;
            inc_check = 1'b1;
          end else begin
            ram_re = 1'b1;
          end
        end
      end
      ST_LOOKUP: begin
        if (!hit) begin
          pop_o     = 1'b1;
          inc_check = 1'b1;
        end else if (out_free) begin
          pop_o     = 1'b1;
          inc_check = 1'b1;
          inc_hit   = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = rd;
          ram_wdata.fires = fires_next;
        end
      end
      default: ;
    endcase
  end

  assign out_load = inc_hit;

  always_comb begin
    check_d  = check_q + 64'(inc_check);
    block_d  = block_q + 64'(inc_hit && is_block);
    log_d    = log_q + 64'(inc_hit && is_log);
    export_d = export_q + 64'(inc_hit);
    out_valid_d = out_valid_q;
    if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      check_q     <= '0;
      block_q     <= '0;
      log_q       <= '0;
      export_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      check_q     <= check_d;
      block_q     <= block_d;
      log_q       <= log_d;
      export_q    <= export_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_blocked_q                <= is_block;
      out_data_q.hit_kind          <= rd.kind;
      out_data_q.hit_number        <= job_i.number;
      out_data_q.hit_pid           <= job_i.pid;
      out_data_q.hit_time          <= job_i.time_ns;
      out_data_q.hit_name_low      <= job_i.proc_low;
      out_data_q.hit_name_high     <= job_i.proc_high[31:0];
      out_data_q.slot_fires        <= fires_next;
      out_data_q.checked_total     <= check_d;
      out_data_q.blocked_total     <= block_d;
      out_data_q.logged_total      <= log_d;
      out_data_q.exported_total    <= export_d;
    end
  end

  assign clear_busy_o = state_q == ST_CLEAR;
  assign m_tvalid_o   = out_valid_q;
  assign m_tdata_o    = out_data_q;
  assign m_tuser_o    = out_blocked_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_o |-> job_valid_i)
    else $error("back popped with no job");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("rule table read and written in one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_load |-> (!out_valid_q || m_tready_i))
    else $error("result overwritten before delivery");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_blocked_q) |-> out_data_q.hit_kind == KIND_BLOCK)
    else $error("blocked result without block rule");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == ST_CLEAR |-> !pop_o && !out_load)
    else $error("job handled during table clear");

endmodule

// ===== rtl/syscall_rule_filter.sv =====
`timescale 1ns / 1ps

// Syscall rule filter.
// Input stream s_axis_*: tuser[0] is the opcode (0 check, 1 load). A load writes
// the rule slot named by call_number and clears its fire count; a check looks up
// the slot for call_number and emits one event on m_axis_* when the slot is valid,
// enabled and its name prefix matches the process name. Loads never emit.
// Output stream m_axis_*: tuser[0] is was_blocked, tdata the event and counters.
// Flow: the front takes a request into a two-entry queue. The back pops a load or
// an out-of-table check in its idle state; an in-table check starts a registered
// rule table read there and ends in the lookup state with match, fire-count
// update and write back. The back finishes each check before it takes the next
// job from the queue. Events leave through an output register.
// Reset: after rst_ni rises, the back sweeps the rule table, one slot a cycle,
// through all RULE_SLOTS slots; s_axis_tready_o stays low during the sweep.
// Stall: a held result waits in the output register; the back stops in its
// lookup state on the next hit, the queue fills, and then s_axis_tready_o drops.
module syscall_rule_filter import srf_pkg::*; #(
  parameter int unsigned RULE_SLOTS = RULE_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // call_number, process_id, time_ns, proc_name_low, proc_name_high, new_kind,
  // new_enabled, new_name_low, new_name_high, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // opcode
  input  logic [0:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // hit_kind, hit_number, hit_pid, hit_time, hit_name_low, hit_name_high,
  // slot_fires, checked_total, blocked_total, logged_total, exported_total
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // was_blocked
  output logic [0:0]            m_axis_tuser_o
);

  logic clear_busy;
  logic q_full;
  logic push;
  logic pop;
  logic q_valid;
  job_t in_job;
  job_t head_job;

  srf_front #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_front (
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_o   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .s_tuser_i    (s_axis_tuser_i),
    .clear_busy_i (clear_busy),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (in_job)
  );

  srf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (in_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  srf_back #(
    .RULE_SLOTS (RULE_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (q_valid),
    .job_i        (head_job),
    .pop_o        (pop),
    .clear_busy_o (clear_busy),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tready_i   (m_axis_tready_i),
    .m_tdata_o    (m_axis_tdata_o),
    .m_tuser_o    (m_axis_tuser_o)
  );

endmodule
